// File: hw/rtl/crc8fp_pkg.sv
// Shared types, register map, reset values and CRC-8 update for the frame packer.
package crc8fp_pkg;

    localparam int ByteW = 8;
    localparam int LenW  = 7;
    localparam int IdxW  = 3;

    typedef enum logic [IdxW-1:0] {
        REG_SYNC       = 3'd0,
        REG_ATT_CMD    = 3'd1,
        REG_STAT_CMD   = 3'd2,
        REG_ATT_LEN    = 3'd3,
        REG_STAT_LEN   = 3'd4
    } t_reg_idx;

    localparam logic [ByteW-1:0] SyncReset    = 8'hAA;
    localparam logic [ByteW-1:0] AttCmdReset  = 8'h14;
    localparam logic [ByteW-1:0] StatCmdReset = 8'h18;
    localparam logic [LenW-1:0]  AttLenReset  = 7'd12;
    localparam logic [LenW-1:0]  StatLenReset = 7'd50;
    localparam logic [ByteW-1:0] CrcInit      = 8'hFF;
    localparam logic [ByteW-1:0] CrcPolyRefl  = 8'h8C;
    localparam logic [ByteW-1:0] HeaderExtra  = 8'd4;

    typedef struct packed {
        logic             kind;
        logic [ByteW-1:0] payload_byte;
    } t_in;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             frame_end;
        logic             last_of_run;
    } t_out;

    typedef struct packed {
        logic [ByteW-1:0] sync_byte;
        logic [ByteW-1:0] attitude_command;
        logic [ByteW-1:0] status_command;
        logic [LenW-1:0]  attitude_payload_length;
        logic [LenW-1:0]  status_payload_length;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic             last;
        logic [ByteW-1:0] sync_byte;
        logic [ByteW-1:0] len_byte;
        logic [ByteW-1:0] cmd_byte;
        logic [ByteW-1:0] data_byte;
    } t_job;

    typedef struct packed {
        logic in_frame;
        logic kind;
    } t_front_stat;

    function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                     input logic [ByteW-1:0] data);
        logic [ByteW-1:0] c;
        c = crc ^ data;
        for (int b = 0; b < ByteW; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPolyRefl;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/crc8fp_cfg.sv
// Configuration register file of the frame packer.
module crc8fp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [crc8fp_pkg::IdxW-1:0]   i_cfg_idx,
    input  logic [crc8fp_pkg::ByteW-1:0]  i_cfg_wdata,
    output crc8fp_pkg::t_cfg              o_cfg
);
    import crc8fp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte               <= SyncReset;
            r_cfg.attitude_command        <= AttCmdReset;
            r_cfg.status_command          <= StatCmdReset;
            r_cfg.attitude_payload_length <= AttLenReset;
            r_cfg.status_payload_length   <= StatLenReset;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SYNC:     r_cfg.sync_byte               <= i_cfg_wdata;
                REG_ATT_CMD:  r_cfg.attitude_command        <= i_cfg_wdata;
                REG_STAT_CMD: r_cfg.status_command          <= i_cfg_wdata;
                REG_ATT_LEN:  r_cfg.attitude_payload_length <= i_cfg_wdata[LenW-1:0];
                REG_STAT_LEN: r_cfg.status_payload_length   <= i_cfg_wdata[LenW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/crc8fp_front.sv
// Front end: accepts payload beats, tracks frame position and builds jobs.
module crc8fp_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  crc8fp_pkg::t_in          i_in,
    input  crc8fp_pkg::t_cfg         i_cfg,
    input  logic                     i_q_full,
    output logic                     o_job_push,
    output crc8fp_pkg::t_job         o_job,
    output crc8fp_pkg::t_front_stat  o_stat
);
    import crc8fp_pkg::*;

    logic            r_in_frame;
    logic            r_kind;
    logic [LenW-1:0] r_bytes_sent;

    logic            kind;
    logic [LenW-1:0] raw_len;
    logic [LenW-1:0] len;
    logic [LenW-1:0] n_bytes_sent;
    logic            last;

    always_comb begin
        kind         = r_in_frame ? r_kind : i_in.kind;
        raw_len      = kind ? i_cfg.status_payload_length : i_cfg.attitude_payload_length;
        len          = (raw_len == '0) ? LenW'(1) : raw_len;
        n_bytes_sent = (r_in_frame ? r_bytes_sent : '0) + LenW'(1);
        last         = (n_bytes_sent == '0) || (n_bytes_sent >= len);

        o_job_push      = i_push && !i_q_full;
        o_job.start     = !r_in_frame;
        o_job.last      = last;
        o_job.sync_byte = i_cfg.sync_byte;
        o_job.len_byte  = ByteW'({1'b0, len}) + HeaderExtra;
        o_job.cmd_byte  = kind ? i_cfg.status_command : i_cfg.attitude_command;
        o_job.data_byte = i_in.payload_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_kind       <= 1'b0;
            r_bytes_sent <= '0;
        end else if (o_job_push) begin
            r_kind <= kind;
            if (last) begin
                r_in_frame   <= 1'b0;
                r_bytes_sent <= '0;
            end else begin
                r_in_frame   <= 1'b1;
                r_bytes_sent <= n_bytes_sent;
            end
        end
    end

    assign o_stat.in_frame = r_in_frame;
    assign o_stat.kind     = r_kind;

endmodule

// File: hw/rtl/crc8fp_queue.sv
// Two-entry job queue between front end and back end.
module crc8fp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  crc8fp_pkg::t_job  i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output crc8fp_pkg::t_job  o_head
);
    import crc8fp_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wr_ptr] <= i_job;
                r_wr_ptr        <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push && !o_full, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/crc8fp_back.sv
// Back end: sequences header, data and trailer bytes, runs the CRC, holds the output beat.
module crc8fp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  crc8fp_pkg::t_job  i_job,
    output logic              o_job_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output crc8fp_pkg::t_out  o_out
);
    import crc8fp_pkg::*;

    typedef enum logic [2:0] {
        ST_NEW,
        ST_SYNC,
        ST_LEN,
        ST_CMD,
        ST_DATA,
        ST_TRAIL
    } t_step;

    t_step            r_step;
    logic [ByteW-1:0] r_crc;
    t_out             r_out;
    logic             r_out_valid;

    t_step            cur;
    t_step            n_step;
    logic             go;
    logic             end_job;
    logic [ByteW-1:0] out_byte;
    logic             frame_end;
    logic             last_of_run;
    logic [ByteW-1:0] crc_in;

    always_comb begin
        cur = (r_step == ST_NEW) ? (i_job.start ? ST_SYNC : ST_DATA) : r_step;
        go  = i_job_valid && (!r_out_valid || i_pop);

        out_byte    = i_job.data_byte;
        frame_end   = 1'b0;
        last_of_run = 1'b0;
        end_job     = 1'b0;
        n_step      = ST_NEW;
        case (cur)
            ST_SYNC: begin
                out_byte = i_job.sync_byte;
                n_step   = ST_LEN;
            end
            ST_LEN: begin
                out_byte = i_job.len_byte;
                n_step   = ST_CMD;
            end
            ST_CMD: begin
                out_byte = i_job.cmd_byte;
                n_step   = ST_DATA;
            end
            ST_DATA: begin
                out_byte    = i_job.data_byte;
                last_of_run = !i_job.last;
                end_job     = !i_job.last;
                n_step      = i_job.last ? ST_TRAIL : ST_NEW;
            end
            ST_TRAIL: begin
                out_byte    = r_crc;
                frame_end   = 1'b1;
                last_of_run = 1'b1;
                end_job     = 1'b1;
                n_step      = ST_NEW;
            end
            default: begin
                n_step = ST_NEW;
            end
        endcase

        crc_in    = (cur == ST_SYNC) ? CrcInit : r_crc;
        o_job_pop = go && end_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_NEW;
            r_crc       <= CrcInit;
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_step            <= n_step;
            r_out.out_byte    <= out_byte;
            r_out.frame_end   <= frame_end;
            r_out.last_of_run <= last_of_run;
            r_out_valid       <= 1'b1;
            if (cur != ST_TRAIL) begin
                r_crc <= crc8_update(crc_in, out_byte);
            end
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

endmodule

// File: hw/rtl/crc8_frame_packer.sv
// Top level of the CRC-8 framed packet encoder.
//
// Input side: a queue-style write port. A payload beat (kind, payload_byte) is
// taken on a clock edge with push high and full low. The kind is used only on
// the first beat of a frame.
// Output side: a queue-style read port. While empty is low, o_out carries the
// oldest byte of the framed stream; pop high on that edge takes it.
// A frame is: sync, length (payload + 4), command, payload bytes, CRC-8 trailer.
// The CRC-8 uses polynomial 0x31 (reflected 0x8C), init 0xFF, over header and payload.
// A taken beat is queued; the back end registers one output byte per cycle
// while a job waits and pop keeps up. A frame's first beat adds sync, length
// and command, its last the CRC trailer. The two-entry job queue lets the input
// keep taking beats while output stalls; full rises once both entries are held.
// A stalled pop holds the output beat. The user writes configuration registers
// through i_cfg_we/i_cfg_idx/i_cfg_wdata only while the block is idle; the block
// does not enforce this. Reset restores register defaults and closes any frame.
module crc8_frame_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  crc8fp_pkg::t_in               i_in,
    output logic                          empty,
    input  logic                          pop,
    output crc8fp_pkg::t_out              o_out,
    input  logic                          i_cfg_we,
    input  logic [crc8fp_pkg::IdxW-1:0]   i_cfg_idx,
    input  logic [crc8fp_pkg::ByteW-1:0]  i_cfg_wdata
);
    import crc8fp_pkg::*;

    t_cfg        cfg;
    t_job        job_in;
    t_job        job_head;
    t_front_stat front_stat;
    logic        job_push;
    logic        q_full;
    logic        q_valid;
    logic        job_pop;

    crc8fp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    crc8fp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_q_full   (q_full),
        .o_job_push (job_push),
        .o_job      (job_in),
        .o_stat     (front_stat)
    );

    crc8fp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (job_pop),
        .o_valid (q_valid),
        .o_head  (job_head)
    );

    crc8fp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

    assign full = q_full;

    a_trailer_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.frame_end) |-> o_out.last_of_run)
        else $error("trailer beat without last_of_run");

    a_open_after_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_push && !job_in.last) |=> front_stat.in_frame)
        else $error("frame not open after a non-final beat");

    a_closed_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_push && job_in.last) |=> !front_stat.in_frame)
        else $error("frame still open after its final beat");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !full && !front_stat.in_frame))
        else $error("state not cleared by reset");

endmodule

// File: tb/crc8_frame_packer_checker.sv
// Checker for the frame packer: predicts the framed byte stream and compares every output beat.
`timescale 1ns / 100ps

module crc8_frame_packer_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  crc8fp_pkg::t_in               i_in,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  crc8fp_pkg::t_out              i_out,
    input  logic                          i_cfg_we,
    input  logic [crc8fp_pkg::IdxW-1:0]   i_cfg_idx,
    input  logic [crc8fp_pkg::ByteW-1:0]  i_cfg_wdata,
    output int                            o_errors,
    output int                            o_pending
);
    import crc8fp_pkg::*;

    t_cfg             cfg;
    logic             framing;
    logic             frame_kind;
    logic [LenW-1:0]  sent;
    logic [ByteW-1:0] crc;
    t_out             stream_q[$];
    t_out             want;
    int               fail_count = 0;
    int               depth = 0;

    assign o_errors  = fail_count;
    assign o_pending = depth;

    function automatic logic [ByteW-1:0] crc_next(input logic [ByteW-1:0] crc_in,
                                                  input logic [ByteW-1:0] b);
        logic [ByteW-1:0] r;
        logic             fb;
        r = crc_in;
        for (int i = 0; i < ByteW; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CrcPolyRefl;
            end
        end
        return r;
    endfunction

    function automatic logic [LenW-1:0] frame_limit(input logic k);
        logic [LenW-1:0] n;
        n = k ? cfg.status_payload_length : cfg.attitude_payload_length;
        return (n == '0) ? LenW'(1) : n;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic stream_byte(input logic [ByteW-1:0] b);
        crc = crc_next(crc, b);
        stream_q.push_back(t_out'{b, 1'b0, 1'b0});
    endtask

    task automatic predict_beat(input t_in beat);
        logic [LenW-1:0] lim;
        t_out            tail;
        if (!framing) begin
            frame_kind = beat.kind;
            crc        = CrcInit;
            sent       = '0;
            framing    = 1'b1;
            lim        = frame_limit(frame_kind);
            stream_byte(cfg.sync_byte);
            stream_byte(ByteW'({1'b0, lim}) + HeaderExtra);
            stream_byte(frame_kind ? cfg.status_command : cfg.attitude_command);
        end
        lim = frame_limit(frame_kind);
        stream_byte(beat.payload_byte);
        sent = sent + 1'b1;
        if (sent == '0 || sent >= lim) begin
            stream_q.push_back(t_out'{crc, 1'b1, 1'b0});
            framing = 1'b0;
            sent    = '0;
            crc     = CrcInit;
        end
        tail = stream_q.pop_back();
        tail.last_of_run = 1'b1;
        stream_q.push_back(tail);
    endtask

    task automatic apply_write(input logic [IdxW-1:0] idx, input logic [ByteW-1:0] data);
        case (idx)
            REG_SYNC:     cfg.sync_byte = data;
            REG_ATT_CMD:  cfg.attitude_command = data;
            REG_STAT_CMD: cfg.status_command = data;
            REG_ATT_LEN:  cfg.attitude_payload_length = data[LenW-1:0];
            REG_STAT_LEN: cfg.status_payload_length = data[LenW-1:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.sync_byte               = SyncReset;
            cfg.attitude_command        = AttCmdReset;
            cfg.status_command          = StatCmdReset;
            cfg.attitude_payload_length = AttLenReset;
            cfg.status_payload_length   = StatLenReset;
            framing    = 1'b0;
            frame_kind = 1'b0;
            sent       = '0;
            crc        = CrcInit;
            stream_q.delete();
        end else begin
            if (i_cfg_we) begin
                apply_write(i_cfg_idx, i_cfg_wdata);
            end
            if (i_pop && !i_empty) begin
                if (stream_q.size() == 0) begin
                    report($sformatf("unexpected beat %02h end %0b last %0b",
                                     i_out.out_byte, i_out.frame_end, i_out.last_of_run));
                end else begin
                    want = stream_q.pop_front();
                    if (i_out.out_byte !== want.out_byte) begin
                        report($sformatf("out_byte %02h, want %02h",
                                         i_out.out_byte, want.out_byte));
                    end
                    if (i_out.frame_end !== want.frame_end) begin
                        report($sformatf("frame_end %0b, want %0b (byte %02h)",
                                         i_out.frame_end, want.frame_end, want.out_byte));
                    end
                    if (i_out.last_of_run !== want.last_of_run) begin
                        report($sformatf("last_of_run %0b, want %0b (byte %02h)",
                                         i_out.last_of_run, want.last_of_run, want.out_byte));
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_beat(i_in);
            end
        end
        depth = stream_q.size();
    end

endmodule

// File: tb/crc8_frame_packer_tb.sv
// Testbench top for the frame packer: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 100ps

module crc8_frame_packer_tb;
    import crc8fp_pkg::*;

    localparam int              IdleLimit      = 2000;
    localparam int              RandomBeats    = 160;
    localparam int              LongHold       = 120;
    localparam logic [IdxW-1:0] RegUnusedFirst = 3'd5;
    localparam logic [IdxW-1:0] RegUnusedLast  = 3'd7;

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    t_in              i_in;
    logic             empty;
    logic             pop;
    t_out             o_out;
    logic             i_cfg_we;
    logic [IdxW-1:0]  i_cfg_idx;
    logic [ByteW-1:0] i_cfg_wdata;

    int errors;
    int pending;
    int quiet_cycles = 0;
    int rx_hold = 0;
    bit rx_no_gaps = 1'b0;
    bit tx_no_gaps = 1'b0;
    int random_sent = 0;

    crc8_frame_packer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    crc8_frame_packer_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_in        (i_in),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= IdleLimit) begin
                $display("crc8_frame_packer_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(3, 1);
        end else if (r < 97) begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(40, 20);
    endfunction

    function automatic logic [ByteW-1:0] pick_byte();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return ByteW'($urandom_range(255, 0));
    endfunction

    function automatic logic [ByteW-1:0] pick_len_word(input bit big);
        logic            msb;
        logic [LenW-1:0] n;
        int              r;
        msb = 1'($urandom_range(1, 0));
        r   = $urandom_range(9, 0);
        if (big) begin
            n = LenW'($urandom_range(127, 125));
        end else if (r == 0) begin
            n = '0;
        end else begin
            n = LenW'($urandom_range(8, 1));
        end
        return {msb, n};
    endfunction

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [ByteW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send(input logic k, input logic [ByteW-1:0] b);
        t_in beat;
        int  gap;
        beat.kind         = k;
        beat.payload_byte = b;
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_in <= beat;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_random();
        send(1'($urandom_range(1, 0)), ByteW'($urandom_range(255, 0)));
        random_sent++;
    endtask

    // hold the sender until the stream has fully drained
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic shuffle_config(input bit all_regs, input bit big);
        if (all_regs || $urandom_range(1, 0)) write_reg(REG_SYNC, pick_byte());
        if (all_regs || $urandom_range(1, 0)) write_reg(REG_ATT_CMD, pick_byte());
        if (all_regs || $urandom_range(1, 0)) write_reg(REG_STAT_CMD, pick_byte());
        if (all_regs || big || $urandom_range(1, 0)) write_reg(REG_ATT_LEN, pick_len_word(big));
        if (all_regs || $urandom_range(1, 0)) write_reg(REG_STAT_LEN, pick_len_word(1'b0));
        if ($urandom_range(7, 0) == 0) begin
            write_reg(IdxW'($urandom_range(RegUnusedLast, RegUnusedFirst)), pick_byte());
        end
    endtask

    initial begin
        int hold;
        int gap;
        pop = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                hold    = rx_hold;
                rx_hold = 0;
                @(negedge i_clk);
                pop <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            gap = rx_no_gaps ? 0 : pick_gap();
            if (gap > 0) begin
                @(negedge i_clk);
                pop <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin
        int phase;
        int count;
        int big_len;
        push        = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // reset values, then shorten the length of the open frame
        send(1'b0, 8'h00);
        drain();
        write_reg(REG_ATT_LEN, 8'd1);
        send(1'b1, 8'hFF);
        drain();

        // extremes: zero length, masked 127 length, all-zero and all-one codes
        write_reg(REG_SYNC, 8'hFF);
        write_reg(REG_ATT_CMD, 8'h00);
        write_reg(REG_STAT_CMD, 8'hFF);
        write_reg(REG_ATT_LEN, 8'h00);
        write_reg(REG_STAT_LEN, 8'hFF);
        send(1'b0, 8'h00);
        send(1'b1, 8'hFF);
        repeat (3) send(1'($urandom_range(1, 0)), ByteW'($urandom_range(255, 0)));
        drain();
        write_reg(REG_STAT_LEN, 8'd2);
        write_reg(REG_SYNC, 8'h00);
        send(1'b0, 8'h5A);
        send(1'b1, 8'hA5);
        send(1'b0, 8'h3C);
        drain();
        for (int k = RegUnusedFirst; k <= RegUnusedLast; k++) begin
            write_reg(k[IdxW-1:0], ByteW'($urandom_range(255, 0)));
        end
        write_reg(REG_ATT_LEN, 8'd3);
        repeat (3) send(1'b0, ByteW'($urandom_range(255, 0)));
        drain();

        // back-pressure: receiver holds off while the sender streams
        shuffle_config(1'b1, 1'b0);
        rx_hold    = LongHold;
        tx_no_gaps = 1'b1;
        repeat (16) send_random();
        tx_no_gaps = 1'b0;
        drain();

        phase = 0;
        while (random_sent < RandomBeats) begin
            shuffle_config(1'b0, phase == 2);
            tx_no_gaps = ($urandom_range(5, 0) == 0);
            rx_no_gaps = ($urandom_range(5, 0) == 0);
            if (phase == 2) begin
                write_reg(REG_STAT_LEN, 8'd1);
                big_len = $urandom_range(127, 125);
                write_reg(REG_ATT_LEN, ByteW'(big_len));
                repeat (big_len + 10) begin
                    send(1'b0, ByteW'($urandom_range(255, 0)));
                    random_sent++;
                end
            end else begin
                count = $urandom_range(20, 3);
                repeat (count) send_random();
            end
            drain();
            phase++;
        end
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;

        drain();
        repeat (8) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("crc8_frame_packer_tb: done, clean");
        end else begin
            $display("crc8_frame_packer_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: crc8_frame_packer.f
hw/rtl/crc8fp_pkg.sv
hw/rtl/crc8fp_cfg.sv
hw/rtl/crc8fp_front.sv
hw/rtl/crc8fp_queue.sv
hw/rtl/crc8fp_back.sv
hw/rtl/crc8_frame_packer.sv
tb/crc8_frame_packer_checker.sv
tb/crc8_frame_packer_tb.sv
